// ===== rtl/fsa_pkg.sv =====
// Shared types and codes for the fallback schedule alarm.
`timescale 1ns / 1ps

package fsa_pkg;

  localparam logic [1:0] ACT_TICK      = 2'd0;
  localparam logic [1:0] ACT_HEARTBEAT = 2'd1;
  localparam logic [1:0] ACT_HEADER    = 2'd2;
  localparam logic [1:0] ACT_ENTRY     = 2'd3;

  localparam logic [7:0] CFG_LOST_AFTER   = 8'd0;
  localparam logic [7:0] CFG_REFIRE_GUARD = 8'd1;

  localparam logic [15:0] LOST_AFTER_RESET   = 16'd60;
  localparam logic [7:0]  REFIRE_GUARD_RESET = 8'd65;
  localparam logic [7:0]  NO_SCHEDULE_DAY    = 8'hFF;
  localparam int          WRITE_SLOTS        = 16;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] track;
    logic [7:0] volume;
    logic [3:0] loops;
    logic       enabled;
  } slot_t;

  typedef struct packed {
    logic       en;
    logic [3:0] index;
    slot_t      slot;
  } slot_wr_t;

  typedef struct packed {
    logic       valid;
    logic       found;
    logic [7:0] track;
    logic [7:0] volume;
    logic [3:0] loops;
    logic [3:0] entry;
  } token_t;

endpackage

// ===== rtl/fsa_cell.sv =====
// One table slot of the alarm chain; matches the search token as it passes.
`timescale 1ns / 1ps

module fsa_cell
  import fsa_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  slot_wr_t         wr,
  input  logic [4:0]       hour,
  input  logic [5:0]       minute,
  input  logic [CNT_W-1:0] count,
  input  token_t           tin,
  output token_t           tout
);

  slot_t slot;
  logic  selected;
  logic  hit;

  assign selected = (INDEX < WRITE_SLOTS) && (wr.index == 4'(INDEX));
  assign hit = tin.valid && !tin.found && slot.enabled && (slot.hour == hour) &&
               (slot.minute == minute) && (count > CNT_W'(INDEX));

  always_ff @(posedge clk) begin
    if (wr.en && selected) begin
      slot <= wr.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
      tout.found <= 1'b0;
    end else begin
      tout.valid <= tin.valid;
      tout.found <= tin.found || hit;
    end
    // take the first hit, pass everything else along
    if (hit) begin
      tout.track  <= slot.track;
      tout.volume <= slot.volume;
      tout.loops  <= slot.loops;
      tout.entry  <= 4'(INDEX);
    end else begin
      tout.track  <= tin.track;
      tout.volume <= tin.volume;
      tout.loops  <= tin.loops;
      tout.entry  <= tin.entry;
    end
  end

endmodule

// ===== rtl/fallback_schedule_alarm.sv =====
// Top level: time-of-day clock, heartbeat watch and a chain of alarm slots.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  item    | start, busy          | action, time_*, entry_*, header_*
//  result  | strobe (one cycle)   | play_track, play_volume, play_loops, play_entry
//  config  | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// Heartbeat, header and entry items finish in the idle state. A tick goes to
// an evaluate state and, when the fire conditions hold, to a scan state: one
// search token walks the slot chain one cell per cycle, and a hit gives the strobe.
// Reset (rst, synchronous) clears clock, counters and schedule header; table
// slots hold garbage until written. The receiver cannot stall the result.
`timescale 1ns / 1ps

module fallback_schedule_alarm
  import fsa_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [4:0]  time_hour,
  input  logic [5:0]  time_minute,
  input  logic [5:0]  time_second,
  input  logic        time_valid,
  input  logic [3:0]  entry_index,
  input  logic [7:0]  entry_track,
  input  logic [7:0]  entry_volume,
  input  logic [3:0]  entry_loops,
  input  logic        entry_enabled,
  input  logic [7:0]  header_day,
  input  logic [7:0]  header_count,
  output logic        strobe,
  output logic [7:0]  play_track,
  output logic [7:0]  play_volume,
  output logic [3:0]  play_loops,
  output logic [3:0]  play_entry,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]       state;
  logic [15:0]      lost_after;
  logic [7:0]       refire_guard;
  logic [4:0]       clock_hour;
  logic [5:0]       clock_minute;
  logic [5:0]       clock_second;
  logic             clock_valid;
  logic [15:0]      silent_seconds;
  logic [10:0]      fired_key;
  logic             fired_key_valid;
  logic [7:0]       fired_age;
  logic [7:0]       schedule_day;
  logic [CNT_W-1:0] entry_count;

  logic             accept;
  logic [10:0]      clock_key;
  logic             guard_block;
  logic             launch;
  logic [CNT_W-1:0] count_next;
  slot_wr_t         wr;
  token_t           tok [MAX_ENTRIES+1];

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign clock_key   = ({6'd0, clock_hour} * 11'd60) + {5'd0, clock_minute};
  assign guard_block = fired_key_valid && (fired_key == clock_key) &&
                       (fired_age < refire_guard);
  assign launch = (state == S_EVAL) && (silent_seconds >= lost_after) &&
                  (entry_count != '0) && (schedule_day != NO_SCHEDULE_DAY) &&
                  clock_valid && !guard_block;

  assign count_next = ({24'd0, header_count} > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                            : CNT_W'(header_count);

  assign wr.en          = accept && (action == ACT_ENTRY);
  assign wr.index       = entry_index;
  assign wr.slot.hour   = time_hour;
  assign wr.slot.minute = time_minute;
  assign wr.slot.track  = entry_track;
  assign wr.slot.volume = entry_volume;
  assign wr.slot.loops  = entry_loops;
  assign wr.slot.enabled = entry_enabled;

  assign tok[0].valid  = launch;
  assign tok[0].found  = 1'b0;
  assign tok[0].track  = '0;
  assign tok[0].volume = '0;
  assign tok[0].loops  = '0;
  assign tok[0].entry  = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    fsa_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .wr     (wr),
      .hour   (clock_hour),
      .minute (clock_minute),
      .count  (entry_count),
      .tin    (tok[i]),
      .tout   (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lost_after   <= LOST_AFTER_RESET;
      refire_guard <= REFIRE_GUARD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LOST_AFTER) begin
        lost_after <= cfg_data;
      end else if (cfg_index == CFG_REFIRE_GUARD) begin
        refire_guard <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      clock_hour      <= '0;
      clock_minute    <= '0;
      clock_second    <= '0;
      clock_valid     <= 1'b0;
      silent_seconds  <= '0;
      fired_key       <= '0;
      fired_key_valid <= 1'b0;
      fired_age       <= '0;
      schedule_day    <= NO_SCHEDULE_DAY;
      entry_count     <= '0;
      strobe          <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_TICK: begin
                // advance clock, wrap at midnight
                if (clock_valid) begin
                  if (clock_second < 6'd59) begin
                    clock_second <= clock_second + 6'd1;
                  end else begin
                    clock_second <= '0;
                    if (clock_minute < 6'd59) begin
                      clock_minute <= clock_minute + 6'd1;
                    end else begin
                      clock_minute <= '0;
                      clock_hour   <= (clock_hour < 5'd23) ? clock_hour + 5'd1 : 5'd0;
                    end
                  end
                end
                if (silent_seconds != 16'hFFFF) begin
                  silent_seconds <= silent_seconds + 16'd1;
                end
                if (fired_age != 8'hFF) begin
                  fired_age <= fired_age + 8'd1;
                end
                state <= S_EVAL;
              end
              ACT_HEARTBEAT: begin
                silent_seconds <= '0;
                if (time_valid && (time_hour <= 5'd23) && (time_minute <= 6'd59) &&
                    (time_second <= 6'd59)) begin
                  clock_hour   <= time_hour;
                  clock_minute <= time_minute;
                  clock_second <= time_second;
                  clock_valid  <= 1'b1;
                end
              end
              ACT_HEADER: begin
                schedule_day <= header_day;
                entry_count  <= count_next;
              end
              default: begin
                // slot write happens inside the cells
              end
            endcase
          end
        end
        S_EVAL: begin
          state <= launch ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          if (tok[MAX_ENTRIES].valid) begin
            state <= S_IDLE;
            if (tok[MAX_ENTRIES].found) begin
              strobe          <= 1'b1;
              fired_key       <= clock_key;
              fired_key_valid <= 1'b1;
              fired_age       <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && tok[MAX_ENTRIES].valid && tok[MAX_ENTRIES].found) begin
      play_track  <= tok[MAX_ENTRIES].track;
      play_volume <= tok[MAX_ENTRIES].volume;
      play_loops  <= tok[MAX_ENTRIES].loops;
      play_entry  <= tok[MAX_ENTRIES].entry;
    end
  end

endmodule

// ===== dv/fsa_alarm_checker.sv =====
// Checker for the fallback schedule alarm: predicts alarms and compares the strobed results.
`timescale 1ns / 1ps

module fsa_alarm_checker
  import fsa_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action,
  input  logic [4:0]  time_hour,
  input  logic [5:0]  time_minute,
  input  logic [5:0]  time_second,
  input  logic        time_valid,
  input  logic [3:0]  entry_index,
  input  logic [7:0]  entry_track,
  input  logic [7:0]  entry_volume,
  input  logic [3:0]  entry_loops,
  input  logic        entry_enabled,
  input  logic [7:0]  header_day,
  input  logic [7:0]  header_count,
  input  logic        strobe,
  input  logic [7:0]  play_track,
  input  logic [7:0]  play_volume,
  input  logic [3:0]  play_loops,
  input  logic [3:0]  play_entry,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic [31:0] fail_count,
  output logic [31:0] pending,
  output logic [31:0] alarm_count
);

  typedef struct packed {
    logic [7:0] track;
    logic [7:0] volume;
    logic [3:0] loops;
    logic [3:0] entry;
  } play_t;

  // Shadow copy of the block's registers and state.
  logic [15:0] lost_after;
  logic [7:0]  guard;
  logic [4:0]  tod_hour;
  logic [5:0]  tod_min;
  logic [5:0]  tod_sec;
  logic        tod_valid;
  logic [15:0] silent;
  logic [10:0] last_key;
  logic        last_key_valid;
  logic [7:0]  age;
  logic [7:0]  sched_day;
  int          sched_count;
  slot_t       alarm_slots [SLOTS];

  play_t       alarms_due [$];
  int          mismatches;
  int          checked;

  initial begin
    fail_count  = '0;
    pending     = '0;
    alarm_count = '0;
    mismatches  = 0;
    checked     = 0;
  end

  // Advance the clock and counters, then search the table for a due alarm.
  function automatic bit predict_tick(output play_t due);
    logic [10:0] minute_key;
    int          i;
    due = '0;
    if (tod_valid) begin
      if (tod_sec < 6'd59) begin
        tod_sec++;
      end else begin
        tod_sec = '0;
        if (tod_min < 6'd59) begin
          tod_min++;
        end else begin
          tod_min = '0;
          if (tod_hour < 5'd23) tod_hour++;
          else tod_hour = '0;
        end
      end
    end
    if (silent != 16'hFFFF) silent++;
    if (age != 8'hFF) age++;
    if (silent < lost_after || sched_count == 0 || sched_day == NO_SCHEDULE_DAY || !tod_valid)
      return 0;
    minute_key = tod_hour * 11'd60 + tod_min;
    if (last_key_valid && last_key == minute_key && age < guard)
      return 0;
    for (i = 0; i < SLOTS; i++) begin
      if (i < sched_count && alarm_slots[i].enabled &&
          alarm_slots[i].hour == tod_hour && alarm_slots[i].minute == tod_min) begin
        due.track      = alarm_slots[i].track;
        due.volume     = alarm_slots[i].volume;
        due.loops      = alarm_slots[i].loops;
        due.entry      = i[3:0];
        last_key       = minute_key;
        last_key_valid = 1'b1;
        age            = '0;
        return 1;
      end
    end
    return 0;
  endfunction

  task automatic note_miss(input string why, input play_t want, input play_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ERROR %s: expected track %0d volume %0d loops %0d entry %0d",
               $realtime, why, want.track, want.volume, want.loops, want.entry);
      $display("    got track %0d volume %0d loops %0d entry %0d",
               got.track, got.volume, got.loops, got.entry);
    end
  endtask

  always @(posedge clk) begin
    play_t due;
    play_t seen;
    if (rst) begin
      lost_after     = LOST_AFTER_RESET;
      guard          = REFIRE_GUARD_RESET;
      tod_hour       = '0;
      tod_min        = '0;
      tod_sec        = '0;
      tod_valid      = 1'b0;
      silent         = '0;
      last_key       = '0;
      last_key_valid = 1'b0;
      age            = '0;
      sched_day      = NO_SCHEDULE_DAY;
      sched_count    = 0;
      alarms_due.delete();
    end else begin
      // Compare first: a result never belongs to a transaction taken at the same edge.
      if (strobe) begin
        seen = {play_track, play_volume, play_loops, play_entry};
        if (alarms_due.size() == 0) begin
          note_miss("alarm with none predicted", '0, seen);
        end else begin
          due = alarms_due.pop_front();
          checked++;
          if (seen.track !== due.track || seen.volume !== due.volume ||
              seen.loops !== due.loops || seen.entry !== due.entry)
            note_miss("alarm mismatch", due, seen);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOST_AFTER:   lost_after = cfg_data;
          CFG_REFIRE_GUARD: guard = cfg_data[7:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (action)
          ACT_TICK: begin
            if (predict_tick(due)) alarms_due.push_back(due);
          end
          ACT_HEARTBEAT: begin
            silent = '0;
            if (time_valid && time_hour <= 5'd23 && time_minute <= 6'd59 &&
                time_second <= 6'd59) begin
              tod_hour  = time_hour;
              tod_min   = time_minute;
              tod_sec   = time_second;
              tod_valid = 1'b1;
            end
          end
          ACT_HEADER: begin
            sched_day   = header_day;
            sched_count = (header_count > SLOTS) ? SLOTS : int'(header_count);
          end
          default: begin
            if (entry_index < SLOTS)
              alarm_slots[entry_index] = '{hour: time_hour, minute: time_minute,
                                           track: entry_track, volume: entry_volume,
                                           loops: entry_loops, enabled: entry_enabled};
          end
        endcase
      end
    end
    pending     <= alarms_due.size();
    fail_count  <= mismatches;
    alarm_count <= checked;
  end

endmodule

// ===== dv/fallback_schedule_alarm_test.sv =====
// Testbench top for the fallback schedule alarm: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module fallback_schedule_alarm_test;
  import fsa_pkg::*;

  localparam int TABLE_SLOTS   = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int IDLE_LIMIT    = 2000;

  typedef struct packed {
    logic [1:0] act;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       tvalid;
    logic [3:0] index;
    logic [7:0] track;
    logic [7:0] volume;
    logic [3:0] loops;
    logic       enabled;
    logic [7:0] day;
    logic [7:0] count;
  } alarm_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = '0;
  logic [4:0]  time_hour = '0;
  logic [5:0]  time_minute = '0;
  logic [5:0]  time_second = '0;
  logic        time_valid = 1'b0;
  logic [3:0]  entry_index = '0;
  logic [7:0]  entry_track = '0;
  logic [7:0]  entry_volume = '0;
  logic [3:0]  entry_loops = '0;
  logic        entry_enabled = 1'b0;
  logic [7:0]  header_day = '0;
  logic [7:0]  header_count = '0;
  logic        strobe;
  logic [7:0]  play_track;
  logic [7:0]  play_volume;
  logic [3:0]  play_loops;
  logic [3:0]  play_entry;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic [31:0] fail_count;
  logic [31:0] pending;
  logic [31:0] alarm_count;

  int sent = 0;
  int reg_writes = 0;
  int steady_left = 0;
  int idle_cycles = 0;

  fallback_schedule_alarm #(.MAX_ENTRIES(TABLE_SLOTS)) dut (.*);

  fsa_alarm_checker #(.SLOTS(TABLE_SLOTS)) checker_i (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Stop a hung run: nothing accepted on any channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("fallback_schedule_alarm: mismatch");
        $finish;
      end
    end
  end

  function automatic alarm_cmd_t random_cmd();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    random_cmd = bits[$bits(alarm_cmd_t)-1:0];
  endfunction

  function automatic alarm_cmd_t tick_cmd();
    tick_cmd = random_cmd();
    tick_cmd.act = ACT_TICK;
  endfunction

  function automatic alarm_cmd_t heartbeat_cmd(input logic [4:0] h, input logic [5:0] m,
                                               input logic [5:0] s, input logic v);
    heartbeat_cmd        = random_cmd();
    heartbeat_cmd.act    = ACT_HEARTBEAT;
    heartbeat_cmd.hour   = h;
    heartbeat_cmd.minute = m;
    heartbeat_cmd.second = s;
    heartbeat_cmd.tvalid = v;
  endfunction

  function automatic alarm_cmd_t header_cmd(input logic [7:0] d, input logic [7:0] n);
    header_cmd       = random_cmd();
    header_cmd.act   = ACT_HEADER;
    header_cmd.day   = d;
    header_cmd.count = n;
  endfunction

  function automatic alarm_cmd_t entry_cmd(input logic [3:0] idx, input logic [4:0] h,
                                           input logic [5:0] m, input logic en);
    entry_cmd         = random_cmd();
    entry_cmd.act     = ACT_ENTRY;
    entry_cmd.index   = idx;
    entry_cmd.hour    = h;
    entry_cmd.minute  = m;
    entry_cmd.enabled = en;
  endfunction

  // Hold start high until the block takes the transaction; leave it high.
  task automatic send(input alarm_cmd_t c);
    start         <= 1'b1;
    action        <= c.act;
    time_hour     <= c.hour;
    time_minute   <= c.minute;
    time_second   <= c.second;
    time_valid    <= c.tvalid;
    entry_index   <= c.index;
    entry_track   <= c.track;
    entry_volume  <= c.volume;
    entry_loops   <= c.loops;
    entry_enabled <= c.enabled;
    header_day    <= c.day;
    header_count  <= c.count;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Mostly back to back or short gaps, a few long ones, and stretches with none.
  task automatic pause_random();
    int n;
    int r;
    n = 0;
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else if (r < 97) n = $urandom_range(4, 12);
      else n = $urandom_range(20, 40);
      if ($urandom_range(0, 63) == 0) steady_left = $urandom_range(20, 80);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(input alarm_cmd_t c);
    pause_random();
    send(c);
  endtask

  // Drain every predicted alarm, then give a tick that finds nothing time to finish.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // Load entries around a chosen time, sync the clock, then let the heartbeat go silent.
  // A sharp scene fires once and resyncs to the same minute near the saturated age.
  task automatic play_scene(input int lost, input bit sharp);
    int          hh;
    int          mm;
    int          ss;
    int          cnt;
    int          tm;
    int          r;
    int          extra;
    logic [4:0]  eh;
    logic [5:0]  em;
    logic [3:0]  idx;
    logic [7:0]  day;
    logic [7:0]  hcnt;
    logic        en;
    hh = $urandom_range(0, 23);
    mm = $urandom_range(0, 59);
    if ($urandom_range(0, 3) == 0) begin
      mm = 59;
      if ($urandom_range(0, 1) == 0) hh = 23;
    end
    ss    = sharp ? $urandom_range(0, 50) : $urandom_range(0, 59);
    cnt   = $urandom_range(1, TABLE_SLOTS);
    extra = (lost <= 120) ? lost : 0;
    repeat (sharp ? 1 : $urandom_range(1, 3)) begin
      tm  = (hh * 60 + mm + (sharp ? 0 : $urandom_range(0, 2))) % 1440;
      eh  = 5'(tm / 60);
      em  = 6'(tm % 60);
      r   = $urandom_range(0, 15);
      if (!sharp && r == 0) eh = 5'($urandom_range(24, 31));
      else if (!sharp && r == 1) em = 6'($urandom_range(60, 63));
      idx = (sharp || r != 2) ? 4'($urandom_range(0, cnt - 1))
                              : 4'($urandom_range(0, TABLE_SLOTS - 1));
      en  = sharp || ($urandom_range(0, 7) != 0);
      issue(entry_cmd(idx, eh, em, en));
    end
    day  = 8'($urandom_range(0, 254));
    hcnt = 8'(cnt);
    r    = $urandom_range(0, 19);
    if (!sharp && r == 0) day = NO_SCHEDULE_DAY;
    else if (!sharp && r == 1) hcnt = '0;
    else if (!sharp && r == 2) hcnt = 8'($urandom_range(TABLE_SLOTS + 1, 255));
    issue(header_cmd(day, hcnt));
    r = $urandom_range(0, 19);
    if (!sharp && r == 0) issue(heartbeat_cmd(5'(hh), 6'(mm), 6'(ss), 1'b0));
    else if (!sharp && r == 1)
      issue(heartbeat_cmd(5'($urandom_range(24, 31)), 6'(mm), 6'(ss), 1'b1));
    else if (!sharp && r == 2)
      issue(heartbeat_cmd(5'(hh), 6'(mm), 6'($urandom_range(60, 63)), 1'b1));
    else issue(heartbeat_cmd(5'(hh), 6'(mm), 6'(ss), 1'b1));
    repeat (sharp ? 1 : $urandom_range(10, 110) + extra) issue(tick_cmd());
    if (sharp || $urandom_range(0, 2) == 0) begin
      repeat (sharp ? $urandom_range(250, 256) : $urandom_range(0, 70)) issue(tick_cmd());
      issue(heartbeat_cmd(5'(hh), 6'(mm), 6'(ss), 1'b1));
      repeat ($urandom_range(5, 60) + extra) issue(tick_cmd());
    end
  endtask

  task automatic run_phase(input int lost, input int guard, input bit program_regs);
    int goal;
    if (program_regs) begin
      write_reg(CFG_LOST_AFTER, lost[15:0]);
      write_reg(CFG_REFIRE_GUARD, {8'($urandom), guard[7:0]});
    end
    goal = sent + 60;
    while (sent < goal) begin
      repeat ($urandom_range(0, 12)) issue(random_cmd());
      play_scene(lost, guard == 255 && $urandom_range(0, 2) != 0);
    end
  endtask

  initial begin
    alarm_cmd_t c;
    int         i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fill every slot first so no search ever reads an unwritten one.
    c = entry_cmd(4'd0, 5'd0, 6'd0, 1'b1);
    c.track = 8'd0; c.volume = 8'd255; c.loops = 4'd15;
    issue(c);
    c = entry_cmd(4'd15, 5'd23, 6'd59, 1'b1);
    c.track = 8'd255; c.volume = 8'd0; c.loops = 4'd0;
    issue(c);
    issue(entry_cmd(4'd1, 5'd31, 6'd63, 1'b1));
    issue(entry_cmd(4'd2, 5'd23, 6'd60, 1'b1));
    for (i = 3; i < TABLE_SLOTS - 1; i++)
      issue(entry_cmd(4'(i), 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                      1'($urandom_range(0, 1))));
    issue(header_cmd(NO_SCHEDULE_DAY, 8'd16));
    issue(heartbeat_cmd(5'd24, 6'd0, 6'd0, 1'b1));
    issue(heartbeat_cmd(5'd10, 6'd60, 6'd0, 1'b1));
    issue(heartbeat_cmd(5'd10, 6'd0, 6'd63, 1'b1));
    issue(heartbeat_cmd(5'd12, 6'd30, 6'd30, 1'b0));
    issue(heartbeat_cmd(5'd23, 6'd59, 6'd58, 1'b1));
    issue(header_cmd(8'd0, 8'd255));
    issue(tick_cmd());
    issue(tick_cmd());

    run_phase(60, 65, 1'b0);
    run_phase(1, 1, 1'b1);
    run_phase(0, 0, 1'b1);
    run_phase(1, 255, 1'b1);
    run_phase(65535, 0, 1'b1);
    run_phase(3, 65, 1'b1);
    run_phase(2, 5, 1'b1);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d commands and %0d register writes across seven register settings,",
             sent, reg_writes);
    $display("including a silence limit never reached; %0d alarms compared.", alarm_count);
    if (fail_count == 0) begin
      $display("fallback_schedule_alarm: match");
    end else begin
      $display("fallback_schedule_alarm: mismatch");
    end
    $finish;
  end

endmodule
